>>> rtl/core/msvs_pkg.sv
// Package for the MIDI stream volume scaler: action codes, result kinds and
// MIDI byte constants. No dependencies.
package msvs_pkg;

	typedef enum logic [1:0] {
		ACT_BYTE   = 2'd0,
		ACT_MASTER = 2'd1,
		ACT_START  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic {
		KIND_CHAN  = 1'b0,
		KIND_SYSEX = 1'b1
	} kind_t;

	localparam logic [6:0] FULL_VOL    = 7'd127;
	localparam logic [6:0] CTRL_VOLUME = 7'd7;

	localparam logic [7:0] ST_NONE     = 8'h00;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_QFRAME   = 8'hF1;
	localparam logic [7:0] ST_SONGPOS  = 8'hF2;
	localparam logic [7:0] ST_SONGSEL  = 8'hF3;
	localparam logic [7:0] ST_EOX      = 8'hF7;

	localparam logic [3:0] HI_CTRL     = 4'hB;
	localparam logic [3:0] HI_PROG     = 4'hC;
	localparam logic [3:0] HI_CHPRESS  = 4'hD;
	localparam logic [3:0] HI_SYSTEM   = 4'hF;

	localparam logic [1:0] CNT_SYSEX   = 2'd1;
	localparam logic [1:0] CNT_SHORT   = 2'd2;
	localparam logic [1:0] CNT_LONG    = 2'd3;

endpackage

>>> rtl/core/msvs_cmd_if.sv
// Input channel of the MIDI stream volume scaler: valid/ready plus one item.
// Depends on nothing.
interface msvs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] value;
	logic       block_start;

	modport source (output valid, action, value, block_start, input ready);
	modport sink   (input valid, action, value, block_start, output ready);
endinterface

>>> rtl/core/msvs_evt_if.sv
// Result channel of the MIDI stream volume scaler: valid/ready plus one item.
// Depends on nothing.
interface msvs_evt_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] status_byte;
	logic [6:0] first_data;
	logic [6:0] second_data;
	logic [1:0] byte_count;
	logic       last;

	modport source (output valid, kind, status_byte, first_data, second_data,
		byte_count, last, input ready);
	modport sink   (input valid, kind, status_byte, first_data, second_data,
		byte_count, last, output ready);
endinterface

>>> rtl/core/midi_stream_volume_scaler_core.sv
// Top level of the MIDI stream volume scaler: parser, channel volume memory,
// result register. Uses msvs_pkg, msvs_cmd_if, msvs_evt_if, msvs_scale.
//
// cmd takes one item at a time: a MIDI stream byte, a master volume write or
// a song start. evt returns result items, last marking the final one of an
// item; an item may cause none.
// Steps after an item is accepted, with evt free:
//   stream byte, no result:        decode, then cmd.ready again
//   channel or sysex result:       decode, then a load of the result register
//   controller 7 (volume scaled):  decode, multiply, load of the result register
//   master volume write:           decode, then for each channel in turn a
//                                  memory read, a multiply and a load of
//                                  the result register
//   song start:                    decode, no result
// Channel volumes live in a 16 x 7 memory with a registered read;
// per-entry valid bits make a never written or song-start cleared entry read
// as 127, so no clearing pass is needed.
// Reset clears the parser, valid bits, master volume (to 127) and evt.valid.
// A stalled evt holds its item; the block waits in its load state and takes
// no new cmd item until the pending result has been placed in the register.
module midi_stream_volume_scaler_core
	import msvs_pkg::*;
#(
	parameter int CHANNELS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	msvs_cmd_if.sink        cmd,
	msvs_evt_if.source      evt
);
	localparam int CH_W = $clog2(CHANNELS);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_MUL, S_BRD, S_BMUL, S_EMIT
	} st_t;

	st_t             st_q;
	logic [1:0]      act_q;
	logic [7:0]      val_q;
	logic            bs_q;

	logic [7:0]      rs_q;
	logic            dc_q;
	logic [6:0]      hd_q;
	logic            sx_q;
	logic [6:0]      mst_q;
	logic [CHANNELS-1:0] vld_q;
	logic [CH_W-1:0] ch_q;
	logic            bcast_q;

	logic            res_kind_q;
	logic [7:0]      res_st_q;
	logic [6:0]      res_d1_q;
	logic [6:0]      res_d2_q;
	logic [1:0]      res_cnt_q;
	logic            res_scl_q;

	logic            ov_q;
	logic            o_kind_q;
	logic [7:0]      o_st_q;
	logic [6:0]      o_d1_q;
	logic [6:0]      o_d2_q;
	logic [1:0]      o_cnt_q;
	logic            o_last_q;

	logic [6:0]      vol_mem [CHANNELS];
	logic [6:0]      rd_q;

	// parser, combinational over the captured byte
	logic [7:0]      rs_e, rs_n;
	logic            dc_e, dc_n, sx_e, sx_n;
	logic [6:0]      hd_e, hd_n;
	logic            p_has, p_kind, p_scl, p_we;
	logic [7:0]      p_st;
	logic [6:0]      p_d1, p_d2;
	logic [1:0]      p_cnt;

	logic            emit_go, scl_go;
	logic [6:0]      scl_vol, scl_q;
	logic            mem_we;

	assign rs_e = bs_q ? ST_NONE : rs_q;
	assign dc_e = bs_q ? 1'b0 : dc_q;
	assign hd_e = bs_q ? 7'd0 : hd_q;
	assign sx_e = bs_q ? 1'b0 : sx_q;

	always_comb begin
		rs_n   = rs_e;
		dc_n   = dc_e;
		hd_n   = hd_e;
		sx_n   = sx_e;
		p_has  = 1'b0;
		p_kind = KIND_CHAN;
		p_scl  = 1'b0;
		p_we   = 1'b0;
		p_st   = rs_e;
		p_d1   = 7'd0;
		p_d2   = 7'd0;
		p_cnt  = CNT_LONG;
		if (sx_e) begin
			if (val_q == ST_EOX) begin
				sx_n = 1'b0;
			end
			p_has  = 1'b1;
			p_kind = KIND_SYSEX;
			p_st   = val_q;
			p_cnt  = CNT_SYSEX;
		end else if (val_q[7]) begin
			dc_n = 1'b0;
			hd_n = 7'd0;
			if (val_q < ST_SYSEX) begin
				rs_n = val_q;
			end else if (val_q == ST_SYSEX) begin
				rs_n   = ST_NONE;
				sx_n   = 1'b1;
				p_has  = 1'b1;
				p_kind = KIND_SYSEX;
				p_st   = val_q;
				p_cnt  = CNT_SYSEX;
			end else if (val_q == ST_QFRAME || val_q == ST_SONGPOS
				|| val_q == ST_SONGSEL) begin
				rs_n = val_q;
			end else begin
				rs_n = ST_NONE;
			end
		end else if (rs_e == ST_NONE) begin
			rs_n = rs_e;
		end else if (rs_e[7:4] == HI_SYSTEM) begin
			dc_n = (rs_e == ST_SONGPOS) && !dc_e;
		end else if (rs_e[7:4] == HI_PROG || rs_e[7:4] == HI_CHPRESS) begin
			dc_n  = 1'b0;
			p_has = 1'b1;
			p_d1  = val_q[6:0];
			p_cnt = CNT_SHORT;
		end else if (!dc_e) begin
			hd_n = val_q[6:0];
			dc_n = 1'b1;
		end else begin
			dc_n  = 1'b0;
			p_has = 1'b1;
			p_d1  = hd_e;
			p_d2  = val_q[6:0];
			if (rs_e[7:4] == HI_CTRL && hd_e == CTRL_VOLUME) begin
				p_scl = 1'b1;
				p_we  = 1'b1;
			end
		end
	end

	assign emit_go = (st_q == S_EMIT) && (!ov_q || evt.ready);
	assign scl_go  = (st_q == S_MUL) || (st_q == S_BMUL);
	assign scl_vol = (st_q == S_BMUL) ? (vld_q[ch_q] ? rd_q : FULL_VOL) : res_d2_q;
	assign mem_we  = (st_q == S_DEC) && (act_q == ACT_BYTE) && p_we;

	msvs_scale u_scale (
		.clk  (clk),
		.go   (scl_go),
		.vol  (scl_vol),
		.mst  (mst_q),
		.quot (scl_q)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vol_mem[rs_e[CH_W-1:0]] <= val_q[6:0];
		end
		rd_q <= vol_mem[ch_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			rs_q     <= ST_NONE;
			dc_q     <= 1'b0;
			hd_q     <= 7'd0;
			sx_q     <= 1'b0;
			mst_q    <= FULL_VOL;
			vld_q    <= '0;
			ch_q     <= '0;
			bcast_q  <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (emit_go) begin
				ov_q <= 1'b1;
			end else if (evt.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (cmd.valid) begin
						act_q <= cmd.action;
						val_q <= cmd.value;
						bs_q  <= cmd.block_start;
						st_q  <= S_DEC;
					end
				end
				S_DEC: begin
					case (act_q)
						ACT_BYTE: begin
							bcast_q    <= 1'b0;
							rs_q       <= rs_n;
							dc_q       <= dc_n;
							hd_q       <= hd_n;
							sx_q       <= sx_n;
							res_kind_q <= p_kind;
							res_st_q   <= p_st;
							res_d1_q   <= p_d1;
							res_d2_q   <= p_d2;
							res_cnt_q  <= p_cnt;
							res_scl_q  <= p_scl;
							if (p_we) begin
								vld_q[rs_e[CH_W-1:0]] <= 1'b1;
							end
							if (!p_has) begin
								st_q <= S_IDLE;
							end else if (p_scl) begin
								st_q <= S_MUL;
							end else begin
								st_q <= S_EMIT;
							end
						end
						ACT_MASTER: begin
							mst_q   <= val_q[7] ? FULL_VOL : val_q[6:0];
							ch_q    <= '0;
							bcast_q <= 1'b1;
							st_q    <= S_BRD;
						end
						ACT_START: begin
							vld_q <= '0;
							rs_q  <= ST_NONE;
							dc_q  <= 1'b0;
							hd_q  <= 7'd0;
							sx_q  <= 1'b0;
							st_q  <= S_IDLE;
						end
						default: begin
							st_q <= S_IDLE;
						end
					endcase
				end
				S_MUL: begin
					st_q <= S_EMIT;
				end
				S_BRD: begin
					st_q <= S_BMUL;
				end
				S_BMUL: begin
					res_kind_q <= KIND_CHAN;
					res_st_q   <= {HI_CTRL, 4'(ch_q)};
					res_d1_q   <= CTRL_VOLUME;
					res_cnt_q  <= CNT_LONG;
					res_scl_q  <= 1'b1;
					st_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						o_kind_q <= res_kind_q;
						o_st_q   <= res_st_q;
						o_d1_q   <= res_d1_q;
						o_d2_q   <= res_scl_q ? scl_q : res_d2_q;
						o_cnt_q  <= res_cnt_q;
						o_last_q <= !bcast_q || (ch_q == CH_LAST);
						if (bcast_q && ch_q != CH_LAST) begin
							ch_q <= ch_q + 1'b1;
							st_q <= S_BRD;
						end else begin
							st_q <= S_IDLE;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready       = (st_q == S_IDLE);
	assign evt.valid       = ov_q;
	assign evt.kind        = o_kind_q;
	assign evt.status_byte = o_st_q;
	assign evt.first_data  = o_d1_q;
	assign evt.second_data = o_d2_q;
	assign evt.byte_count  = o_cnt_q;
	assign evt.last        = o_last_q;

	a_sysex_no_rs: assert property (@(posedge clk) disable iff (!arst_n)
		sx_q |-> (rs_q == ST_NONE))
		else $error("running status set inside sysex");

	a_dc_needs_rs: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q |-> (rs_q != ST_NONE))
		else $error("pending data byte without running status");

	a_bcast_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && bcast_q && ch_q == CH_LAST) |=> (st_q == S_IDLE) && evt.valid
			&& evt.last)
		else $error("volume broadcast did not end on last channel");

	a_sysex_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.kind == KIND_SYSEX) |-> (evt.byte_count == CNT_SYSEX)
			&& evt.last)
		else $error("malformed sysex result item");
endmodule

>>> rtl/core/msvs_scale.sv
// Volume scaler: registered 7x7 product, then exact division by 127.
// Depends on nothing.
module msvs_scale (
	input  logic       clk,
	input  logic       go,
	input  logic [6:0] vol,
	input  logic [6:0] mst,
	output logic [6:0] quot
);
	logic [13:0] prod_s1;
	logic [14:0] sum;

	always_ff @(posedge clk) begin
		if (go) begin
			prod_s1 <= 14'(vol) * 14'(mst);
		end
	end

	// p/127 == (p + (p >> 7) + 1) >> 7 for p up to 127*127
	assign sum  = {1'b0, prod_s1} + {8'd0, prod_s1[13:7]} + 15'd1;
	assign quot = sum[13:7];
endmodule
